// ===== hdl/fpps_pkg.sv =====
// shared types, constants and codes for the first packet protocol sniffer
package fpps_pkg;

  localparam int BUF_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int COUNT_W   = 13;
  localparam int INDEX_W   = 12;
  localparam int HDR_LEN   = 5;
  localparam int LEN_HI_POS = 4;

  localparam logic [7:0] TLS_FIRST = 8'h16;
  localparam logic [7:0] WS_FIRST  = 8'h47;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [1:0] FUNC_FEED    = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [1:0] ST_NEED = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [1:0] TR_UNKNOWN = 2'd0;
  localparam logic [1:0] TR_TLS     = 2'd1;
  localparam logic [1:0] TR_WS      = 2'd2;

  localparam logic [1:0] MATCH_NONE    = 2'd0;
  localparam logic [1:0] MATCH_CR      = 2'd1;
  localparam logic [1:0] MATCH_CRLF    = 2'd2;
  localparam logic [1:0] MATCH_CRLFCR  = 2'd3;

  typedef enum logic [3:0] {
    OP_FEED    = 4'b0001,
    OP_READ    = 4'b0010,
    OP_RESTART = 4'b0100,
    OP_NOP     = 4'b1000
  } op_t;

  typedef enum logic [2:0] {
    PH_NEED = 3'b001,
    PH_DONE = 3'b010,
    PH_ERR  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         data_byte;
    logic [INDEX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         transport;
    logic               redirect;
    logic [COUNT_W-1:0] want;
    logic [COUNT_W-1:0] buffered_len;
    logic               accepted;
    logic [7:0]         read_data;
  } rsp_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         data_byte;
    logic [INDEX_W-1:0] read_index;
    logic               is_tls;
    logic               is_ws;
    logic               is_cr;
    logic               is_lf;
  } cmd_t;

endpackage

// ===== hdl/fpps_front.sv =====
// front end: decodes a request and classifies its byte into a command
module fpps_front (
  input  fpps_pkg::req_t req,
  output fpps_pkg::cmd_t cmd
);

  always_comb begin
    unique case (req.func)
      fpps_pkg::FUNC_FEED:    cmd.op = fpps_pkg::OP_FEED;
      fpps_pkg::FUNC_READ:    cmd.op = fpps_pkg::OP_READ;
      fpps_pkg::FUNC_RESTART: cmd.op = fpps_pkg::OP_RESTART;
      default:                cmd.op = fpps_pkg::OP_NOP;
    endcase
    cmd.data_byte  = req.data_byte;
    cmd.read_index = req.read_index;
    cmd.is_tls     = (req.data_byte == fpps_pkg::TLS_FIRST);
    cmd.is_ws      = (req.data_byte == fpps_pkg::WS_FIRST);
    cmd.is_cr      = (req.data_byte == fpps_pkg::CH_CR);
    cmd.is_lf      = (req.data_byte == fpps_pkg::CH_LF);
  end

endmodule

// ===== hdl/fpps_queue.sv =====
// two-entry command queue between front and back
module fpps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fpps_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fpps_pkg::cmd_t pop_cmd
);

  fpps_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/fpps_back.sv =====
// back end: sniffer state, packet buffer and result register
module fpps_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  fpps_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fpps_pkg::rsp_t rsp
);

  localparam int CW = fpps_pkg::COUNT_W;

  logic [7:0]            mem [fpps_pkg::BUF_DEPTH];
  logic [7:0]            mem_q;

  fpps_pkg::phase_t      phase, phase_next;
  logic [1:0]            kind, kind_next;
  logic                  redirect_flag, redirect_flag_next;
  logic [CW-1:0]         fill_count, fill_count_next;
  logic [CW-1:0]         expected_len, expected_len_next;
  logic [1:0]            match, match_next;
  logic [7:0]            len_hi, len_hi_next;

  logic                  pop;
  logic                  store;
  logic                  acc;
  logic                  hit;
  logic [15:0]           body;
  logic [16:0]           total;
  logic [CW-1:0]         want;
  logic [1:0]            status;

  logic [1:0]            r_status;
  logic [1:0]            r_transport;
  logic                  r_redirect;
  logic [CW-1:0]         r_want;
  logic [CW-1:0]         r_len;
  logic                  r_acc;
  logic                  r_hit;

  assign pop       = cmd_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign body      = {len_hi, cmd.data_byte};
  assign total     = 17'(fpps_pkg::HDR_LEN) + {1'b0, body};

  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    redirect_flag_next = redirect_flag;
    fill_count_next    = fill_count;
    expected_len_next  = expected_len;
    match_next         = match;
    len_hi_next        = len_hi;
    store              = 1'b0;
    acc                = 1'b0;
    hit                = 1'b0;
    if (pop) begin
      unique case (cmd.op)
        fpps_pkg::OP_FEED: begin
          if (phase == fpps_pkg::PH_NEED) begin
            if (fill_count == CW'(fpps_pkg::BUF_DEPTH)) begin
              phase_next         = fpps_pkg::PH_ERR;
              redirect_flag_next = 1'b1;
            end else begin
              store           = 1'b1;
              acc             = 1'b1;
              fill_count_next = fill_count + CW'(1);
              priority if (kind == fpps_pkg::TR_UNKNOWN) begin
                if (cmd.is_tls) begin
                  kind_next = fpps_pkg::TR_TLS;
                end else if (cmd.is_ws) begin
                  kind_next = fpps_pkg::TR_WS;
                end else begin
                  phase_next         = fpps_pkg::PH_ERR;
                  redirect_flag_next = 1'b1;
                end
              end else if (kind == fpps_pkg::TR_TLS) begin
                if (fill_count_next == CW'(fpps_pkg::LEN_HI_POS)) begin
                  len_hi_next = cmd.data_byte;
                end
                if (fill_count_next == CW'(fpps_pkg::HDR_LEN)) begin
                  if (body == 16'd0 || total > 17'(fpps_pkg::BUF_DEPTH)) begin
                    phase_next         = fpps_pkg::PH_ERR;
                    redirect_flag_next = 1'b1;
                  end else begin
                    expected_len_next = total[CW-1:0];
                  end
                end else if (expected_len != '0 && fill_count_next == expected_len) begin
                  phase_next = fpps_pkg::PH_DONE;
                end
              end else begin
                if (cmd.is_cr) begin
                  match_next = (match == fpps_pkg::MATCH_CRLF) ?
                               fpps_pkg::MATCH_CRLFCR : fpps_pkg::MATCH_CR;
                end else if (cmd.is_lf) begin
                  if (match == fpps_pkg::MATCH_CR) begin
                    match_next = fpps_pkg::MATCH_CRLF;
                  end else if (match == fpps_pkg::MATCH_CRLFCR) begin
                    phase_next = fpps_pkg::PH_DONE;
                  end else begin
                    match_next = fpps_pkg::MATCH_NONE;
                  end
                end else begin
                  match_next = fpps_pkg::MATCH_NONE;
                end
              end
            end
          end
        end
        fpps_pkg::OP_READ: begin
          hit = ({1'b0, cmd.read_index} < fill_count) &&
                ({1'b0, cmd.read_index} < CW'(fpps_pkg::BUF_DEPTH));
        end
        fpps_pkg::OP_RESTART: begin
          phase_next         = fpps_pkg::PH_NEED;
          kind_next          = fpps_pkg::TR_UNKNOWN;
          redirect_flag_next = 1'b0;
          fill_count_next    = '0;
          expected_len_next  = '0;
          match_next         = fpps_pkg::MATCH_NONE;
          len_hi_next        = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_next)
      fpps_pkg::PH_DONE: status = fpps_pkg::ST_DONE;
      fpps_pkg::PH_ERR:  status = fpps_pkg::ST_ERR;
      default:           status = fpps_pkg::ST_NEED;
    endcase
    if (phase_next != fpps_pkg::PH_NEED) begin
      want = '0;
    end else if (kind_next == fpps_pkg::TR_TLS) begin
      if (fill_count_next < CW'(fpps_pkg::HDR_LEN)) begin
        want = CW'(fpps_pkg::HDR_LEN) - fill_count_next;
      end else if (expected_len_next < fill_count_next) begin
        want = '0;
      end else begin
        want = expected_len_next - fill_count_next;
      end
    end else begin
      want = CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[fill_count[fpps_pkg::ADDR_W-1:0]] <= cmd.data_byte;
    end
    if (pop) begin
      mem_q <= mem[cmd.read_index[fpps_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fpps_pkg::PH_NEED;
      kind          <= fpps_pkg::TR_UNKNOWN;
      redirect_flag <= 1'b0;
      fill_count    <= '0;
      expected_len  <= '0;
      match         <= fpps_pkg::MATCH_NONE;
      len_hi        <= 8'd0;
      rsp_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      kind          <= kind_next;
      redirect_flag <= redirect_flag_next;
      fill_count    <= fill_count_next;
      expected_len  <= expected_len_next;
      match         <= match_next;
      len_hi        <= len_hi_next;
      if (pop) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_status    <= status;
      r_transport <= kind_next;
      r_redirect  <= redirect_flag_next;
      r_want      <= want;
      r_len       <= fill_count_next;
      r_acc       <= acc;
      r_hit       <= hit;
    end
  end

  assign rsp.status       = r_status;
  assign rsp.transport    = r_transport;
  assign rsp.redirect     = r_redirect;
  assign rsp.want         = r_want;
  assign rsp.buffered_len = r_len;
  assign rsp.accepted     = r_acc;
  assign rsp.read_data    = r_hit ? mem_q : 8'd0;

  assert property (@(posedge clk) disable iff (rst)
    redirect_flag |-> phase == fpps_pkg::PH_ERR)
    else $error("redirect flag set outside error phase");

  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(fpps_pkg::BUF_DEPTH))
    else $error("fill count beyond buffer depth");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != fpps_pkg::ST_NEED |-> rsp.want == '0)
    else $error("bytes wanted after done or error");

  assert property (@(posedge clk) disable iff (rst)
    store |=> fill_count == $past(fill_count) + CW'(1))
    else $error("buffer write without fill count advance");

endmodule

// ===== hdl/first_packet_protocol_sniffer.sv =====
// a request is held in the command queue, then its result is registered in the back end
// throughput: one request per cycle unless a waiting result stalls the back end
// a two-entry command queue lets the front keep taking requests while a result waits
// reset clears the sniffer state, the queue and the result valid flag
// the packet buffer is not cleared: bytes past the fill count always read as zero
module first_packet_protocol_sniffer (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fpps_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fpps_pkg::rsp_t rsp
);

  fpps_pkg::cmd_t front_cmd;
  fpps_pkg::cmd_t back_cmd;
  logic           back_valid;
  logic           back_ready;

  fpps_front u_front (
    .req (req),
    .cmd (front_cmd)
  );

  fpps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req_valid),
    .push_ready (req_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  fpps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
